[design/rpre_pkg.sv]
// ----------------------------------------------------------------------------
// rpre_pkg: shared types for the raster packet run-length expander
// Word formats for both channels, the run command passed from the parser to
// the expander, parser phase codes and header constants.
// ----------------------------------------------------------------------------
package rpre_pkg;

    // Header layout.
    localparam logic [4:0] HEADER_LEN  = 5'd20;
    localparam logic [4:0] ROWS_HI_POS = 5'd16;
    localparam logic [4:0] ROWS_LO_POS = 5'd17;

    // Run command queue depth (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_word_t;

    // Output word, one pixel.
    typedef struct packed {
        logic [20:0] column;
        logic [15:0] row_number;
        logic [3:0]  level;
        logic        last_of_byte;
    } out_word_t;

    // One nonzero run to expand.
    typedef struct packed {
        logic [20:0] column;
        logic [15:0] row_number;
        logic [3:0]  level;
        logic [3:0]  run;
    } run_cmd_t;

    // Queue handshake between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_HEADER    = 4'b0010,
        PH_ROW_COUNT = 4'b0100,
        PH_ROW_DATA  = 4'b1000
    } phase_t;

endpackage

[design/rpre_front.sv]
// ----------------------------------------------------------------------------
// rpre_front: packet parser
// Walks the header, row counts and data bytes, and turns each data byte with
// a nonzero run into a run command for the expander.
// ----------------------------------------------------------------------------
module rpre_front
    import rpre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  in_word_t      word,
    output logic          push,
    output run_cmd_t      cmd
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] rows_total_reg, rows_total_next;
    logic [15:0] current_row_reg, current_row_next;
    logic [16:0] bytes_left_reg, bytes_left_next;
    logic [20:0] next_column_reg, next_column_next;
    logic [7:0]  hold_reg, hold_next;

    // Parser step for one accepted word.
    always_comb
    begin
        phase_t      ph;
        logic [4:0]  idx;
        logic [15:0] rows;
        logic [15:0] row;
        logic [16:0] left;
        logic [20:0] col;
        logic [7:0]  hold;
        logic [4:0]  idx_inc;
        logic [15:0] count;
        logic [15:0] row_inc;
        logic [3:0]  run;
        logic        row_done;

        ph   = phase_reg;
        idx  = idx_reg;
        rows = rows_total_reg;
        row  = current_row_reg;
        left = bytes_left_reg;
        col  = next_column_reg;
        hold = hold_reg;

        idx_inc  = 5'd0;
        count    = 16'd0;
        row_inc  = 16'd0;
        run      = word.data_byte[7:4];
        row_done = 1'b0;
        push     = 1'b0;

        cmd.column     = next_column_reg;
        cmd.row_number = current_row_reg;
        cmd.level      = word.data_byte[3:0];
        cmd.run        = run;

        if (accept)
        begin
            // A start flag restarts the packet from any phase.
            if (word.packet_start)
            begin
                ph   = PH_HEADER;
                idx  = 5'd0;
                rows = 16'd0;
                row  = 16'd0;
                left = 17'd0;
                col  = 21'd0;
                hold = 8'd0;
            end

            unique case (ph)
                PH_HEADER:
                begin
                    if (idx == ROWS_HI_POS)
                    begin
                        hold = word.data_byte;
                    end
                    else if (idx == ROWS_LO_POS)
                    begin
                        rows = {hold, word.data_byte};
                    end
                    idx_inc = idx + 5'd1;
                    if (idx_inc >= HEADER_LEN)
                    begin
                        idx = 5'd0;
                        row = 16'd0;
                        col = 21'd0;
                        ph  = (rows == 16'd0) ? PH_IDLE : PH_ROW_COUNT;
                    end
                    else
                    begin
                        idx = idx_inc;
                    end
                end
                PH_ROW_COUNT:
                begin
                    if (idx == 5'd0)
                    begin
                        hold = word.data_byte;
                        idx  = 5'd1;
                    end
                    else
                    begin
                        count = {hold, word.data_byte};
                        left  = {count, 1'b0};
                        col   = 21'd0;
                        idx   = 5'd0;
                        if (count == 16'd0)
                        begin
                            row_done = 1'b1;
                        end
                        else
                        begin
                            ph = PH_ROW_DATA;
                        end
                    end
                end
                PH_ROW_DATA:
                begin
                    push = (run != 4'd0);
                    cmd.column     = col;
                    cmd.row_number = row;
                    col  = col + {17'd0, run};
                    left = left - 17'd1;
                    if (left == 17'd0)
                    begin
                        row_done = 1'b1;
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase

            // End of a row: move to the next row count or go idle.
            if (row_done)
            begin
                row_inc = row + 16'd1;
                row  = row_inc;
                idx  = 5'd0;
                col  = 21'd0;
                left = 17'd0;
                ph   = (row_inc >= rows) ? PH_IDLE : PH_ROW_COUNT;
            end
        end

        phase_next       = ph;
        idx_next         = idx;
        rows_total_next  = rows;
        current_row_next = row;
        bytes_left_next  = left;
        next_column_next = col;
        hold_next        = hold;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            idx_reg         <= 5'd0;
            rows_total_reg  <= 16'd0;
            current_row_reg <= 16'd0;
            bytes_left_reg  <= 17'd0;
            next_column_reg <= 21'd0;
            hold_reg        <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            rows_total_reg  <= rows_total_next;
            current_row_reg <= current_row_next;
            bytes_left_reg  <= bytes_left_next;
            next_column_reg <= next_column_next;
            hold_reg        <= hold_next;
        end
    end

endmodule

[design/rpre_queue.sv]
// ----------------------------------------------------------------------------
// rpre_queue: run command queue
// Small first-in first-out buffer that decouples the parser from the
// pixel expander.
// ----------------------------------------------------------------------------
module rpre_queue
    import rpre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  run_cmd_t      push_cmd,
    input  logic          pop,
    output run_cmd_t      head_cmd,
    output queue_status_t status
);

    run_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    localparam logic [QUEUE_AW:0] FULL_COUNT = QUEUE_DEPTH[QUEUE_AW:0];

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/rpre_back.sv]
// ----------------------------------------------------------------------------
// rpre_back: pixel expander
// Takes run commands from the queue and emits one pixel per cycle while the
// receiver is ready, into an output register that holds while it stalls.
// ----------------------------------------------------------------------------
module rpre_back
    import rpre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  run_cmd_t      head_cmd,
    input  queue_status_t status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output out_word_t     out_data
);

    run_cmd_t   cur_reg;
    logic       busy_reg, busy_next;
    logic [3:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_reg;
    logic       load;
    logic       last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // While busy, a pixel loads if the output register is free or drains now.
    assign load = busy_reg && (!out_valid_reg || out_ready);
    assign last = ((k_reg + 4'd1) == cur_reg.run);
    assign pop  = !status.empty && (!busy_reg || (load && last));

    always_comb
    begin
        busy_next      = busy_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            k_next         = k_reg + 4'd1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
            k_next    = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
        if (load)
        begin
            out_reg.column       <= cur_reg.column + {17'd0, k_reg};
            out_reg.row_number   <= cur_reg.row_number;
            out_reg.level        <= cur_reg.level;
            out_reg.last_of_byte <= last;
        end
    end

endmodule

[design/raster_packet_rle_expander.sv]
// ----------------------------------------------------------------------------
// raster_packet_rle_expander: raster packet run-length decoder
// Input channel in_valid/in_ready/in_data carries one packet byte per word,
// with packet_start set on header byte 0. Output channel out_valid/out_ready/
// out_data carries one pixel per word (column, row, level, last_of_byte).
// The parser takes a byte every cycle while its run queue has room; header,
// row-count and zero-run bytes produce no pixels. A data byte with run n
// yields n pixels, one per cycle from the expander while the receiver is
// ready, so sustained throughput is set by the expander. The first pixel of
// a byte passes through the queue entry, the command register and then the
// output register. When the receiver stalls, the output register holds its
// word, the expander waits, the four-entry queue fills and then in_ready
// drops.
// Reset clears the parser to idle and empties the queue and output register;
// bytes arriving while idle without packet_start are dropped.
// ----------------------------------------------------------------------------
module raster_packet_rle_expander
    import rpre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic          accept;
    logic          push;
    logic          pop;
    run_cmd_t      push_cmd;
    run_cmd_t      head_cmd;
    queue_status_t status;

    assign in_ready = !status.full;
    assign accept   = in_valid && in_ready;

    // Parser front end.
    rpre_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (in_data),
        .push   (push),
        .cmd    (push_cmd)
    );

    // Run command queue.
    rpre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    // Pixel expander back end.
    rpre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .status    (status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
